// ----- sv/mvei_pkg.sv -----
// Package for the mesh vertex and edge indexer.
// Holds store depths, derived widths, shared types and status codes.
// No dependencies.
package mvei_pkg;

  // Store depths.
  localparam int VTX_DEPTH  = 4096;
  localparam int EDGE_DEPTH = 4096;
  localparam int MAX_FACETS = 1024;

  // Derived widths.
  localparam int VTX_AW    = $clog2(VTX_DEPTH);
  localparam int EDGE_AW   = $clog2(EDGE_DEPTH);
  localparam int FACET_AW  = $clog2(MAX_FACETS);
  localparam int VTX_CW    = VTX_AW + 1;
  localparam int EDGE_CW   = EDGE_AW + 1;
  localparam int FACET_CW  = FACET_AW + 1;
  localparam int COORD_W   = 32;
  localparam int NORM_W    = 16;
  localparam int USE_W     = 12;
  localparam int THR_W     = 64;
  localparam int KEY_W     = 2 * VTX_AW;
  localparam int VRAM_W    = 3 * COORD_W;
  localparam int FRAM_W    = 3 * VTX_AW + 3 * EDGE_AW + 3 * NORM_W;

  localparam logic [USE_W-1:0] USE_MAX   = '1;
  localparam logic [THR_W-1:0] THR_RESET = 64'd429497;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_VTX_FULL   = 2'd1,
    ST_EDGE_FULL  = 2'd2,
    ST_FACET_FULL = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_VSCAN,
    S_VRES,
    S_VDRAIN,
    S_ESCAN,
    S_ERES,
    S_FCHK,
    S_URD,
    S_UWR,
    S_DONE
  } state_t;

  // Tag that travels with a candidate vertex through the distance pipeline.
  typedef struct packed {
    logic              valid;
    logic [VTX_AW-1:0] idx;
  } vtag_t;

  typedef logic [2:0][COORD_W-1:0] coord3_t;

endpackage

// ----- sv/mesh_vertex_edge_indexer_top.sv -----
// Top level of the mesh vertex and edge indexer: sequencer, stores and result register.
// Depends on mvei_pkg, mvei_ram and mvei_weld_pipe.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | normal_x..z, corner0_x .. corner2_z
//   out     | out_valid / out_stall| facet_total, vertex_index_*, edge_*, status
//   cfg     | cfg_valid / cfg_ready| weld_threshold
//
// The vertex store is read one entry a cycle into the distance pipeline, then the edge
// store one entry a cycle, then use counts are updated in place. A new first or second
// corner is also run through the distance pipeline against the later corners.
// Reset empties all stores at once through their totals; no clearing pass.
// A new item is taken whenever the sequencer is idle, even with a result waiting;
// a stalled result holds the sequencer in its final state.
module mesh_vertex_edge_indexer_top import mvei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   normal_x,
  input  logic signed [15:0]   normal_y,
  input  logic signed [15:0]   normal_z,
  input  logic signed [31:0]   corner0_x,
  input  logic signed [31:0]   corner0_y,
  input  logic signed [31:0]   corner0_z,
  input  logic signed [31:0]   corner1_x,
  input  logic signed [31:0]   corner1_y,
  input  logic signed [31:0]   corner1_z,
  input  logic signed [31:0]   corner2_x,
  input  logic signed [31:0]   corner2_y,
  input  logic signed [31:0]   corner2_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [10:0]          facet_total,
  output logic [11:0]          vertex_index_0,
  output logic [11:0]          vertex_index_1,
  output logic [11:0]          vertex_index_2,
  output logic [11:0]          edge_index_0,
  output logic [11:0]          edge_index_1,
  output logic [11:0]          edge_index_2,
  output logic [11:0]          edge_uses_0,
  output logic [11:0]          edge_uses_1,
  output logic [11:0]          edge_uses_2,
  output logic [1:0]           status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          weld_threshold
);

  state_t st, st_next;

  // Item registers.
  coord3_t cx, cy, cz;
  logic [2:0][NORM_W-1:0] nrm;
  logic [THR_W-1:0] thr;

  // Committed totals and working totals of the current item.
  logic [VTX_CW-1:0]   vertex_total, nv;
  logic [EDGE_CW-1:0]  edge_total, ne;
  logic [FACET_CW-1:0] facet_count;

  // Per-corner and per-edge results.
  logic [2:0] vfound, efound, eapp;
  logic [2:0][VTX_AW-1:0] vidx;
  logic [2:0][EDGE_AW-1:0] eidx;
  logic [2:0][USE_W-1:0] euse;
  logic [1:0] rc;
  status_t ist;

  // Scan pointers and read stages.
  logic [VTX_CW-1:0]  vptr;
  logic [EDGE_CW-1:0] eptr;
  logic a_valid, a_sel;
  logic [VTX_AW-1:0] a_idx;
  logic [1:0] a_corner;
  logic e_valid;
  logic [EDGE_AW-1:0] e_idx;

  // Memory ports.
  logic vram_we, vuse_we, eend_we, euse_we, fram_we;
  logic [VTX_AW-1:0] vram_raddr, vuse_waddr, vuse_raddr;
  logic [EDGE_AW-1:0] eend_raddr, euse_waddr, euse_raddr;
  logic [VRAM_W-1:0] vram_wdata, vram_rdata;
  logic [USE_W-1:0] vuse_wdata, vuse_rdata, euse_wdata, euse_rdata;
  logic [KEY_W-1:0] eend_rdata;
  logic [FRAM_W-1:0] fram_wdata;

  // Control strobes from the sequencer.
  logic v_issue, v_inject, v_append, e_issue, e_append, e_dup, commit;
  logic dup_hit;
  logic [EDGE_AW-1:0] dup_idx;
  logic [2:0][KEY_W-1:0] key_f, key_r;

  // Pipeline signals.
  vtag_t p_tag_in, p_tag_out;
  logic [2:0] p_hit;
  logic p_busy;
  logic [COORD_W-1:0] pt_x, pt_y, pt_z;

  assign in_stall  = (st != S_IDLE);
  assign cfg_ready = 1'b1;

  // Edge keys: forward {b,a} and reverse {a,b} for each edge.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      key_f[c] = {vidx[(c == 2) ? 0 : c + 1], vidx[c]};
      key_r[c] = {vidx[c], vidx[(c == 2) ? 0 : c + 1]};
    end
  end

  // Match against edges appended earlier in this item; the earliest wins.
  always_comb begin
    dup_hit = 1'b0;
    dup_idx = eidx[0];
    for (int j = 1; j >= 0; j--) begin
      if (j < 32'(rc) && eapp[j]
          && (key_f[j] == key_f[rc] || key_f[j] == key_r[rc])) begin
        dup_hit = 1'b1;
        dup_idx = eidx[j];
      end
    end
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    st_next    = st;
    v_issue    = 1'b0;
    v_inject   = 1'b0;
    v_append   = 1'b0;
    e_issue    = 1'b0;
    e_append   = 1'b0;
    e_dup      = 1'b0;
    commit     = 1'b0;
    vram_we    = 1'b0;
    vuse_we    = 1'b0;
    eend_we    = 1'b0;
    euse_we    = 1'b0;
    fram_we    = 1'b0;
    vram_raddr = vptr[VTX_AW-1:0];
    vram_wdata = {cz[rc], cy[rc], cx[rc]};
    vuse_raddr = vidx[rc];
    vuse_waddr = nv[VTX_AW-1:0];
    vuse_wdata = '0;
    eend_raddr = eptr[EDGE_AW-1:0];
    euse_raddr = eidx[rc];
    euse_waddr = ne[EDGE_AW-1:0];
    euse_wdata = '0;
    fram_wdata = {nrm[2], nrm[1], nrm[0], eidx[2], eidx[1], eidx[0],
                  vidx[2], vidx[1], vidx[0]};
    unique case (st)
      S_IDLE: begin
        if (in_valid) begin
          st_next = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if (vptr < nv) begin
          v_issue = 1'b1;
        end else if (!a_valid && !p_busy) begin
          st_next = S_VRES;
        end
      end
      S_VRES: begin
        if (vfound[rc]) begin
          st_next = (rc == 2'd2) ? S_ESCAN : S_VRES;
        end else if (nv >= VTX_CW'(VTX_DEPTH)) begin
          st_next = S_DONE;
        end else begin
          v_append = 1'b1;
          vram_we  = 1'b1;
          vuse_we  = 1'b1;
          if (rc == 2'd2) begin
            st_next = S_ESCAN;
          end else begin
            v_inject = 1'b1;
            st_next  = S_VDRAIN;
          end
        end
      end
      S_VDRAIN: begin
        if (!a_valid && !p_busy) begin
          st_next = S_VRES;
        end
      end
      S_ESCAN: begin
        if (eptr < ne) begin
          e_issue = 1'b1;
        end else if (!e_valid) begin
          st_next = S_ERES;
        end
      end
      S_ERES: begin
        if (efound[rc]) begin
          st_next = (rc == 2'd2) ? S_FCHK : S_ERES;
        end else if (dup_hit) begin
          e_dup   = 1'b1;
          st_next = (rc == 2'd2) ? S_FCHK : S_ERES;
        end else if (ne >= EDGE_CW'(EDGE_DEPTH)) begin
          st_next = S_DONE;
        end else begin
          e_append = 1'b1;
          eend_we  = 1'b1;
          euse_we  = 1'b1;
          st_next  = (rc == 2'd2) ? S_FCHK : S_ERES;
        end
      end
      S_FCHK: begin
        st_next = (facet_count >= FACET_CW'(MAX_FACETS)) ? S_DONE : S_URD;
      end
      S_URD: begin
        st_next = S_UWR;
      end
      S_UWR: begin
        vuse_we    = 1'b1;
        euse_we    = 1'b1;
        vuse_waddr = vidx[rc];
        euse_waddr = eidx[rc];
        vuse_wdata = (vuse_rdata < USE_MAX) ? vuse_rdata + 1'b1 : vuse_rdata;
        euse_wdata = (euse_rdata < USE_MAX) ? euse_rdata + 1'b1 : euse_rdata;
        if (rc == 2'd2) begin
          fram_we = 1'b1;
          commit  = 1'b1;
          st_next = S_DONE;
        end else begin
          st_next = S_URD;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= weld_threshold;
    end
  end

  // Read stage in front of the distance pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      a_valid <= v_issue | v_inject;
      e_valid <= e_issue;
    end
    a_sel    <= v_issue;
    a_idx    <= v_issue ? vptr[VTX_AW-1:0] : nv[VTX_AW-1:0];
    a_corner <= rc;
    e_idx    <= eptr[EDGE_AW-1:0];
  end

  // Candidate point: a stored vertex or a corner just appended.
  assign pt_x = a_sel ? vram_rdata[COORD_W-1:0]           : cx[a_corner];
  assign pt_y = a_sel ? vram_rdata[2*COORD_W-1:COORD_W]   : cy[a_corner];
  assign pt_z = a_sel ? vram_rdata[3*COORD_W-1:2*COORD_W] : cz[a_corner];
  assign p_tag_in = '{valid: a_valid, idx: a_idx};

  // Control registers and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_total <= '0;
      edge_total   <= '0;
      facet_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (commit) begin
        vertex_total <= nv;
        edge_total   <= ne;
        facet_count  <= facet_count + 1'b1;
      end
      if (st == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    // Vertex matches come out of the pipeline in store order; keep the first.
    if (p_tag_out.valid) begin
      for (int c = 0; c < 3; c++) begin
        if (!vfound[c] && p_hit[c]) begin
          vfound[c] <= 1'b1;
          vidx[c]   <= p_tag_out.idx;
        end
      end
    end
    // Edge matches, either direction.
    if (e_valid) begin
      for (int c = 0; c < 3; c++) begin
        if (!efound[c] && (eend_rdata == key_f[c] || eend_rdata == key_r[c])) begin
          efound[c] <= 1'b1;
          eidx[c]   <= e_idx;
        end
      end
    end
    if (v_issue) begin
      vptr <= vptr + 1'b1;
    end
    if (e_issue) begin
      eptr <= eptr + 1'b1;
    end
    unique case (st)
      S_IDLE: begin
        cx     <= {corner2_x, corner1_x, corner0_x};
        cy     <= {corner2_y, corner1_y, corner0_y};
        cz     <= {corner2_z, corner1_z, corner0_z};
        nrm    <= {normal_z, normal_y, normal_x};
        nv     <= vertex_total;
        ne     <= edge_total;
        vptr   <= '0;
        eptr   <= '0;
        vfound <= '0;
        efound <= '0;
        eapp   <= '0;
        euse   <= '0;
        rc     <= '0;
        ist    <= ST_OK;
      end
      S_VRES: begin
        if (vfound[rc]) begin
          rc <= (rc == 2'd2) ? 2'd0 : rc + 1'b1;
        end else if (v_append) begin
          vfound[rc] <= 1'b1;
          vidx[rc]   <= nv[VTX_AW-1:0];
          nv         <= nv + 1'b1;
          if (rc == 2'd2) begin
            rc <= '0;
          end
        end else begin
          ist <= ST_VTX_FULL;
        end
      end
      S_VDRAIN: begin
        if (!a_valid && !p_busy) begin
          rc <= rc + 1'b1;
        end
      end
      S_ERES: begin
        if (efound[rc] || e_dup || e_append) begin
          rc <= (rc == 2'd2) ? 2'd0 : rc + 1'b1;
          if (e_dup) begin
            efound[rc] <= 1'b1;
            eidx[rc]   <= dup_idx;
          end else if (e_append) begin
            efound[rc] <= 1'b1;
            eapp[rc]   <= 1'b1;
            eidx[rc]   <= ne[EDGE_AW-1:0];
            ne         <= ne + 1'b1;
          end
        end else begin
          ist <= ST_EDGE_FULL;
        end
      end
      S_FCHK: begin
        if (facet_count >= FACET_CW'(MAX_FACETS)) begin
          ist <= ST_FACET_FULL;
        end
      end
      S_UWR: begin
        // The count after this write is the latest for every equal edge so far.
        for (int j = 0; j < 3; j++) begin
          if (j <= 32'(rc) && eidx[j] == eidx[rc]) begin
            euse[j] <= euse_wdata;
          end
        end
        rc <= rc + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (st == S_DONE && (!out_valid || !out_stall)) begin
      status <= ist;
      if (ist == ST_OK) begin
        facet_total    <= 11'(facet_count);
        vertex_index_0 <= 12'(vidx[0]);
        vertex_index_1 <= 12'(vidx[1]);
        vertex_index_2 <= 12'(vidx[2]);
        edge_index_0   <= 12'(eidx[0]);
        edge_index_1   <= 12'(eidx[1]);
        edge_index_2   <= 12'(eidx[2]);
        edge_uses_0    <= euse[0];
        edge_uses_1    <= euse[1];
        edge_uses_2    <= euse[2];
      end else begin
        facet_total    <= 11'(facet_count);
        vertex_index_0 <= '0;
        vertex_index_1 <= '0;
        vertex_index_2 <= '0;
        edge_index_0   <= '0;
        edge_index_1   <= '0;
        edge_index_2   <= '0;
        edge_uses_0    <= '0;
        edge_uses_1    <= '0;
        edge_uses_2    <= '0;
      end
    end
  end

  // Distance pipeline.
  mvei_weld_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (p_tag_in),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .pt_z    (pt_z),
    .cx      (cx),
    .cy      (cy),
    .cz      (cz),
    .thr     (thr),
    .tag_out (p_tag_out),
    .hit     (p_hit),
    .busy    (p_busy)
  );

  // Vertex coordinate store.
  mvei_ram #(.W(VRAM_W), .D(VTX_DEPTH)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (nv[VTX_AW-1:0]),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  // Vertex use counts.
  mvei_ram #(.W(USE_W), .D(VTX_DEPTH)) u_vuse (
    .clk   (clk),
    .we    (vuse_we),
    .waddr (vuse_waddr),
    .wdata (vuse_wdata),
    .raddr (vuse_raddr),
    .rdata (vuse_rdata)
  );

  // Edge end points.
  mvei_ram #(.W(KEY_W), .D(EDGE_DEPTH)) u_eend (
    .clk   (clk),
    .we    (eend_we),
    .waddr (ne[EDGE_AW-1:0]),
    .wdata (key_f[rc]),
    .raddr (eend_raddr),
    .rdata (eend_rdata)
  );

  // Edge use counts.
  mvei_ram #(.W(USE_W), .D(EDGE_DEPTH)) u_euse (
    .clk   (clk),
    .we    (euse_we),
    .waddr (euse_waddr),
    .wdata (euse_wdata),
    .raddr (euse_raddr),
    .rdata (euse_rdata)
  );

  // Facet store: corners, edges and normal of each facet.
  mvei_ram #(.W(FRAM_W), .D(MAX_FACETS)) u_fram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (facet_count[FACET_AW-1:0]),
    .wdata (fram_wdata),
    .raddr (facet_count[FACET_AW-1:0]),
    .rdata ()
  );

endmodule

// ----- sv/mvei_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module mvei_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mvei_weld_pipe.sv -----
// Three-stage exact squared-distance pipeline: one candidate point against
// the three corners of the current item in parallel. Depends on mvei_pkg.
module mvei_weld_pipe import mvei_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  vtag_t              tag_in,
  input  logic [COORD_W-1:0] pt_x,
  input  logic [COORD_W-1:0] pt_y,
  input  logic [COORD_W-1:0] pt_z,
  input  coord3_t            cx,
  input  coord3_t            cy,
  input  coord3_t            cz,
  input  logic [THR_W-1:0]   thr,
  output vtag_t              tag_out,
  output logic [2:0]         hit,
  output logic               busy
);

  vtag_t tag1, tag2;
  logic [2:0][2:0][COORD_W-1:0] dist1;
  logic [2:0][2:0][2*COORD_W-1:0] sq2;
  logic [2:0][2:0][COORD_W-1:0] dist_comb;
  logic [2:0][THR_W+1:0] sum_comb;

  // Absolute difference of two signed words; the magnitude fits the word width.
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W]) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  // Per-axis differences for each corner.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dist_comb[c][0] = abs_diff(pt_x, cx[c]);
      dist_comb[c][1] = abs_diff(pt_y, cy[c]);
      dist_comb[c][2] = abs_diff(pt_z, cz[c]);
    end
  end

  // Sums of squares; a sum at or above 2^64 can never be below the threshold.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_comb[c] = (THR_W+2)'(sq2[c][0]) + (THR_W+2)'(sq2[c][1])
                  + (THR_W+2)'(sq2[c][2]);
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag_out <= '0;
    end else begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag_out <= tag2;
    end
    dist1 <= dist_comb;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        sq2[c][k] <= (2*COORD_W)'(dist1[c][k]) * (2*COORD_W)'(dist1[c][k]);
      end
      hit[c] <= (sum_comb[c] < (THR_W+2)'(thr));
    end
  end

  assign busy = tag1.valid | tag2.valid | tag_out.valid;

endmodule
